// ===== src/alil_pkg.sv =====
// Package for the array list block: command and status codes, the request
// and response payload types, and the memory access bundle.
// No dependencies.
package alil_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         index;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } out_t;

  // One write and one read per cycle into the element store
  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [POS_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ===== src/alil_mem.sv =====
// Element store: one write port, one read port, registered read data.
// Depends on alil_pkg.
module alil_mem import alil_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  mem_req_t          mem_req,
  output logic [DATA_W-1:0] mem_rdata
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [DATA_W-1:0] mem_r [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem_r[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
  end

  // Read port, registered; data holds until the next read
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= mem_r[mem_req.raddr[AW-1:0]];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

// ===== src/alil_ctrl.sv =====
// Command sequencer for the array list: checks, shift loops through the
// element store, read-out streaming and the output register.
// Depends on alil_pkg; drives alil_mem.
module alil_ctrl import alil_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_rsp,
  output mem_req_t          mem_req,
  input  logic [DATA_W-1:0] mem_rdata
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_INS_PUT,
    S_DEL,
    S_DEL_LAST,
    S_RD,
    S_RD_WAIT,
    S_RESP
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AW-1:0]     pos_r;
  logic [DATA_W-1:0] val_r;
  logic [AW-1:0]     rd_r;
  logic [AW-1:0]     wa_r;
  logic              pend_r;
  logic              first_r;
  logic [DATA_W-1:0] gone_r;
  logic [ST_W-1:0]   st_r;
  logic [POS_W-1:0]  idx_r;
  logic              out_valid_r;
  out_t              out_rsp_r;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             full;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] cnt_m1;
  logic [AW-1:0]    last_a;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == S_RD_WAIT) || (state_r == S_RESP));
  assign full     = (cnt_r >= CNT_W'(CAPACITY));
  assign pos_ext  = CNT_W'(in_req.pos);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign last_a   = cnt_m1[AW-1:0];

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Memory port requests per state
  always_comb begin
    mem_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_req.cmd == CMD_APPEND) && !full) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = POS_W'(cnt_r);
          mem_req.wdata = in_req.value;
        end
      end
      S_INS: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = POS_W'(rd_r);
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = POS_W'(wa_r);
          mem_req.wdata = mem_rdata;
        end
      end
      S_INS_LAST: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = POS_W'(wa_r);
        mem_req.wdata = mem_rdata;
      end
      S_INS_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = POS_W'(pos_r);
        mem_req.wdata = val_r;
      end
      S_DEL: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = POS_W'(rd_r);
        if (pend_r && !first_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = POS_W'(wa_r);
          mem_req.wdata = mem_rdata;
        end
      end
      S_DEL_LAST: begin
        if (!first_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = POS_W'(wa_r);
          mem_req.wdata = mem_rdata;
        end
      end
      S_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = POS_W'(rd_r);
      end
      S_RD_WAIT, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register: loaded by the emitting states, freed when taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            gone_r <= '0;
            pos_r  <= in_req.pos[AW-1:0];
            val_r  <= in_req.value;
            pend_r <= 1'b0;
            unique case (in_req.cmd)
              CMD_APPEND: begin
                if (full) begin
                  st_r  <= ST_FULL;
                  idx_r <= '0;
                end else begin
                  st_r  <= ST_OK;
                  idx_r <= POS_W'(cnt_r);
                  cnt_r <= cnt_r + CNT_W'(1);
                end
                state_r <= S_RESP;
              end
              CMD_INSERT: begin
                idx_r <= in_req.pos;
                priority if (full) begin
                  st_r    <= ST_FULL;
                  state_r <= S_RESP;
                end else if (pos_ext > cnt_r) begin
                  st_r    <= ST_BADPOS;
                  state_r <= S_RESP;
                end else if (pos_ext == cnt_r) begin
                  st_r    <= ST_OK;
                  state_r <= S_INS_PUT;
                end else begin
                  st_r    <= ST_OK;
                  rd_r    <= last_a;
                  state_r <= S_INS;
                end
              end
              CMD_DELETE: begin
                idx_r <= in_req.pos;
                priority if (cnt_r == '0) begin
                  st_r    <= ST_EMPTY;
                  state_r <= S_RESP;
                end else if (pos_ext >= cnt_r) begin
                  st_r    <= ST_BADPOS;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_OK;
                  rd_r    <= in_req.pos[AW-1:0];
                  state_r <= S_DEL;
                end
              end
              CMD_READ: begin
                if (cnt_r == '0) begin
                  st_r    <= ST_EMPTY;
                  idx_r   <= '0;
                  state_r <= S_RESP;
                end else begin
                  rd_r    <= '0;
                  state_r <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // Shift up: read slot rd, write it to rd+1 in the following cycle
        S_INS: begin
          wa_r   <= rd_r + AW'(1);
          pend_r <= 1'b1;
          if (rd_r == pos_r) begin
            state_r <= S_INS_LAST;
          end else begin
            rd_r <= rd_r - AW'(1);
          end
        end
        S_INS_LAST: begin
          pend_r  <= 1'b0;
          state_r <= S_INS_PUT;
        end
        S_INS_PUT: begin
          cnt_r   <= cnt_r + CNT_W'(1);
          state_r <= S_RESP;
        end

        // Shift down: first read is the deleted value, the rest move to rd-1
        S_DEL: begin
          if (pend_r && first_r) begin
            gone_r <= mem_rdata;
          end
          wa_r    <= rd_r - AW'(1);
          pend_r  <= 1'b1;
          first_r <= (rd_r == pos_r);
          if (rd_r == last_a) begin
            state_r <= S_DEL_LAST;
          end else begin
            rd_r <= rd_r + AW'(1);
          end
        end
        S_DEL_LAST: begin
          if (first_r) begin
            gone_r <= mem_rdata;
          end
          pend_r  <= 1'b0;
          first_r <= 1'b0;
          cnt_r   <= cnt_m1;
          state_r <= S_RESP;
        end

        // Read-out: one element per read, held until the output frees
        S_RD: begin
          state_r <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          if (out_free) begin
            out_rsp_r.status <= ST_OK;
            out_rsp_r.data   <= mem_rdata;
            out_rsp_r.index  <= POS_W'(rd_r);
            out_rsp_r.count  <= cnt_r;
            out_rsp_r.last   <= (rd_r == last_a);
            if (rd_r == last_a) begin
              state_r <= S_IDLE;
            end else begin
              rd_r    <= rd_r + AW'(1);
              state_r <= S_RD;
            end
          end
        end

        // Single response for append, insert, delete and empty read-out
        S_RESP: begin
          if (out_free) begin
            out_rsp_r.status <= st_r;
            out_rsp_r.data   <= gone_r;
            out_rsp_r.index  <= idx_r;
            out_rsp_r.count  <= cnt_r;
            out_rsp_r.last   <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/array_list_insert_delete.sv =====
// Top level of the array list: sequencer plus element store.
// Depends on alil_pkg, alil_ctrl and alil_mem.
//
//  Channel  Ports                          Carries
//  input    in_valid, in_stall, in_req     cmd, pos, value
//  output   out_valid, out_stall, out_rsp  status, data, index, count, last
//
// One request at a time; in_stall is high while a request is in progress.
// Append and error cases go straight to the response. Insert at pos < count
// shifts entries pos..count-1 up one and then writes the value; at pos = count
// it writes directly. Delete shifts the entries above pos down one; both move
// one entry per cycle via the single store port. Read-all reads, emits each element.
// Reset clears the count and the sequencer; store contents are not cleared.
// A stalled output holds its response and pauses the sequencer when it has a response to emit.
module array_list_insert_delete import alil_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_req,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_rsp
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  alil_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  alil_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule
